// ===== rtl/core/b2d_pkg.sv =====
package b2d_pkg;

    localparam int NumDigits   = 5;
    localparam int ByteDigits  = 3;
    localparam int WordDigits  = 5;
    localparam int DivStages   = 4;

    // floor(x / 10) == (x * Recip10) >> Recip10Shift for every 16-bit x
    localparam logic [15:0] Recip10      = 16'd52429;
    localparam int          Recip10Shift = 19;

    localparam logic [5:0] AsciiZero = 6'd48;

    // Work item moving down the divide pipeline; dig[k] is the digit of 10^k
    typedef struct packed {
        logic [15:0]                quot;
        logic [NumDigits-1:0][3:0]  dig;
        logic                       word_mode;
        logic                       keep_zeros;
    } b2d_work_t;

endpackage

// ===== rtl/core/b2d_num_if.sv =====
interface b2d_num_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic        word_mode;
    logic        keep_zeros;

    modport source (output valid, output value, output word_mode, output keep_zeros,
                    input ready);
    modport sink (input valid, input value, input word_mode, input keep_zeros,
                  output ready);
endinterface

// ===== rtl/core/b2d_char_if.sv =====
interface b2d_char_if;
    logic       valid;
    logic       ready;
    logic [5:0] digit_char;
    logic       last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink (input valid, input digit_char, input last, output ready);
endinterface

// ===== rtl/core/b2d_div_stage.sv =====
module b2d_div_stage
    import b2d_pkg::*;
#(
    parameter int Pos = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  b2d_work_t up_data,
    input  logic      load,
    output logic      dn_valid,
    output b2d_work_t dn_data
);

    logic      valid_reg;
    logic      valid_next;
    b2d_work_t data_reg;
    b2d_work_t data_next;
    logic [31:0] prod;
    logic [15:0] q;
    logic [15:0] q_times10;
    logic [15:0] rem;

    always_comb
    begin
        prod      = 32'(up_data.quot) * 32'(Recip10);
        q         = 16'(prod >> Recip10Shift);
        q_times10 = {q[12:0], 3'b000} + {q[14:0], 1'b0};
        rem       = up_data.quot - q_times10;

        data_next          = up_data;
        data_next.quot     = q;
        data_next.dig[Pos] = rem[3:0];
        // last stage: the quotient left over is the top digit
        if (Pos == DivStages - 1)
        begin
            data_next.dig[NumDigits-1] = q[3:0];
        end
        valid_next = load ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== rtl/core/b2d_serializer.sv =====
module b2d_serializer
    import b2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    input  b2d_work_t  up_data,
    output logic       up_ready,
    b2d_char_if.source digit
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [2:0]                idx_reg;
    logic [2:0]                idx_next;
    logic [NumDigits-1:0][3:0] dig_reg;
    logic [2:0]                ndig;
    logic [2:0]                start;
    logic                      done;
    logic                      take;

    always_comb
    begin
        ndig = up_data.word_mode ? 3'(WordDigits) : 3'(ByteDigits);
        // highest nonzero digit, or the units digit when all are zero; with zeros kept, the mode's top digit
        start = 3'd0;
        if (up_data.keep_zeros)
        begin
            start = ndig - 3'd1;
        end
        else
        begin
            for (int k = 1; k < NumDigits; k++)
            begin
                if ((3'(k) < ndig) && (up_data.dig[k] != 4'd0))
                begin
                    start = 3'(k);
                end
            end
        end
    end

    always_comb
    begin
        done      = busy_reg && digit.ready && (idx_reg == 3'd0);
        up_ready  = !busy_reg || done;
        take      = up_valid && up_ready;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            busy_next = 1'b1;
            idx_next  = start;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && digit.ready)
        begin
            idx_next = idx_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dig_reg <= up_data.dig;
        end
    end

    assign digit.valid      = busy_reg;
    assign digit.digit_char = AsciiZero + {2'b00, dig_reg[idx_reg]};
    assign digit.last       = (idx_reg == 3'd0);

endmodule

// ===== rtl/core/binary_to_decimal_ascii_core.sv =====
// An accepted request passes the four divide-by-ten stages, then the serializer,
// before its first character. A new request may enter every cycle unless the
// stages are full and the serializer busy. Characters leave one per cycle while
// ready is high; a request yields 1 to 5 of them (3 or 5 with zeros kept).
// Reset (rst_n low, asynchronous) empties the pipeline and the serializer.
module binary_to_decimal_ascii_core
    import b2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    b2d_num_if.sink    number,
    b2d_char_if.source digit
);

    logic      stg_valid [DivStages+1];
    b2d_work_t stg_data  [DivStages+1];
    logic      load      [DivStages];
    logic      ser_ready;

    assign stg_valid[0] = number.valid;
    assign stg_data[0]  = '{quot:       number.word_mode ? number.value
                                                         : {8'h00, number.value[7:0]},
                            dig:        '0,
                            word_mode:  number.word_mode,
                            keep_zeros: number.keep_zeros};

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        load[DivStages-1] = !stg_valid[DivStages] || ser_ready;
        for (int k = DivStages - 2; k >= 0; k--)
        begin
            load[k] = !stg_valid[k+1] || load[k+1];
        end
    end

    assign number.ready = load[0];

    for (genvar s = 0; s < DivStages; s++)
    begin : g_stage
        b2d_div_stage #(
            .Pos (s)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[s]),
            .up_data  (stg_data[s]),
            .load     (load[s]),
            .dn_valid (stg_valid[s+1]),
            .dn_data  (stg_data[s+1])
        );
    end

    b2d_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stg_valid[DivStages]),
        .up_data  (stg_data[DivStages]),
        .up_ready (ser_ready),
        .digit    (digit)
    );

endmodule

// ===== dv/decimal_char_check.sv =====
`timescale 1ns / 1ps
module decimal_char_check
    import b2d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    b2d_num_if   number,
    b2d_char_if  digit,
    output int   fail_count,
    output int   digits_waiting,
    output int   digits_checked
);

    typedef struct packed {
        logic [5:0] digit_char;
        logic       last;
    } digit_rec_t;

    digit_rec_t pending_digits[$];
    int         errors  = 0;
    int         waiting = 0;
    int         checked = 0;

    assign fail_count     = errors;
    assign digits_waiting = waiting;
    assign digits_checked = checked;

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    // Split one request into its decimal characters, most significant first
    function automatic void queue_decimal_digits(input logic [15:0] value,
                                                 input logic word_mode,
                                                 input logic keep_zeros);
        int unsigned num;
        int unsigned digs[WordDigits];
        int          ndig;
        int          first;
        digit_rec_t  rec;

        num  = word_mode ? int'(value) : int'(value[7:0]);
        ndig = word_mode ? WordDigits : ByteDigits;
        for (int i = ndig - 1; i >= 0; i--)
        begin
            digs[i] = num % 10;
            num     = num / 10;
        end
        // Drop leading zeros but always keep the final digit
        first = 0;
        if (!keep_zeros)
        begin
            while (first + 1 < ndig && digs[first] == 0)
                first++;
        end
        for (int i = first; i < ndig; i++)
        begin
            rec.digit_char = AsciiZero + 6'(digs[i]);
            rec.last       = (i == ndig - 1);
            pending_digits.push_back(rec);
        end
    endfunction

    always @(posedge clk)
    begin
        digit_rec_t want;
        if (rst_n)
        begin
            if (digit.valid && digit.ready)
            begin
                if (pending_digits.size() == 0)
                    report_mismatch($sformatf("character %0d with no request pending",
                                              digit.digit_char));
                else
                begin
                    want = pending_digits.pop_front();
                    if (digit.digit_char !== want.digit_char)
                        report_mismatch($sformatf("digit_char got %0d, expected %0d",
                                                  digit.digit_char, want.digit_char));
                    if (digit.last !== want.last)
                        report_mismatch($sformatf("last got %0b, expected %0b",
                                                  digit.last, want.last));
                    checked++;
                end
            end
            if (number.valid && number.ready)
                queue_decimal_digits(number.value, number.word_mode, number.keep_zeros);
            waiting = pending_digits.size();
        end
    end

endmodule

// ===== dv/binary_to_decimal_ascii_core_tb.sv =====
`timescale 1ns / 1ps
module binary_to_decimal_ascii_core_tb;

    localparam int RandomRequests = 310;
    localparam int RandomPhases   = 5;
    localparam int HoldCycles     = 200;
    localparam int WatchdogLimit  = 4000;
    localparam int DrainCycles    = 20;

    logic clk;
    logic rst_n;

    b2d_num_if  number_ch ();
    b2d_char_if digit_ch ();

    int fail_count;
    int digits_waiting;
    int digits_checked;
    int requests_sent = 0;
    int idle_cycles   = 0;
    bit send_steady   = 0;
    bit recv_steady   = 0;
    bit hold_req      = 0;

    binary_to_decimal_ascii_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .digit  (digit_ch)
    );

    decimal_char_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .number         (number_ch),
        .digit          (digit_ch),
        .fail_count     (fail_count),
        .digits_waiting (digits_waiting),
        .digits_checked (digits_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_number(input logic [15:0] v, input logic wm, input logic kz);
        int gap;
        if (!send_steady && $urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            number_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        number_ch.valid      <= 1'b1;
        number_ch.value      <= v;
        number_ch.word_mode  <= wm;
        number_ch.keep_zeros <= kz;
        @(posedge clk);
        while (!number_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_random_number();
        logic [15:0] v;
        logic [15:0] edges[11];
        edges = '{16'd9, 16'd10, 16'd99, 16'd100, 16'd255, 16'd256,
                  16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd65535};
        v = 16'($urandom);
        case ($urandom_range(0, 9))
            4, 5:    v[7:0] = 8'($urandom_range(0, 99));
            6:       v = 16'($urandom_range(0, 999));
            7:       v[7:0] = 8'h00;
            8, 9:    v = edges[$urandom_range(0, 10)];
            default: ;
        endcase
        send_number(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Receiver: runs of ready high or low; a hold request parks it for a long stretch
    initial
    begin
        int run;
        digit_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                digit_ch.ready <= 1'b0;
                run = HoldCycles;
            end
            else if (recv_steady || $urandom_range(0, 2) != 0)
            begin
                digit_ch.ready <= 1'b1;
                run = $urandom_range(1, 8);
            end
            else
            begin
                digit_ch.ready <= 1'b0;
                run = pick_gap();
            end
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (number_ch.valid && number_ch.ready) ||
            (digit_ch.valid && digit_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("binary_to_decimal_ascii_core_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n                <= 1'b0;
        number_ch.valid      <= 1'b0;
        number_ch.value      <= '0;
        number_ch.word_mode  <= 1'b0;
        number_ch.keep_zeros <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero in every mode, range ends, ignored high byte, digit boundaries
        send_number(16'd0, 1'b0, 1'b0);
        send_number(16'd0, 1'b0, 1'b1);
        send_number(16'd0, 1'b1, 1'b0);
        send_number(16'd0, 1'b1, 1'b1);
        send_number(16'd255, 1'b0, 1'b0);
        send_number(16'd255, 1'b0, 1'b1);
        send_number(16'd65535, 1'b1, 1'b0);
        send_number(16'd65535, 1'b1, 1'b1);
        send_number(16'hFF00, 1'b0, 1'b0);
        send_number(16'hFF00, 1'b0, 1'b1);
        send_number(16'hABCD, 1'b0, 1'b0);
        send_number(16'd65535, 1'b0, 1'b1);
        send_number(16'd1, 1'b0, 1'b0);
        send_number(16'd10, 1'b0, 1'b0);
        send_number(16'd100, 1'b0, 1'b0);
        send_number(16'd99, 1'b0, 1'b1);
        send_number(16'd9, 1'b1, 1'b0);
        send_number(16'd10000, 1'b1, 1'b0);
        send_number(16'd9999, 1'b1, 1'b0);
        send_number(16'd60000, 1'b1, 1'b1);
        send_number(16'h5555, 1'b1, 1'b0);
        send_number(16'hAAAA, 1'b1, 1'b1);

        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            send_steady = (phase == 1 || phase == 3);
            recv_steady = (phase == 1);
            // Back up the output while requests keep coming
            if (phase == 3)
                hold_req = 1'b1;
            repeat (RandomRequests / RandomPhases) send_random_number();
        end
        number_ch.valid <= 1'b0;

        @(posedge clk);
        while (digits_waiting != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d requests in byte and word mode, zeros kept and dropped,",
                 requests_sent);
        $display("with a long output hold; %0d characters compared, %0d mismatches",
                 digits_checked, fail_count);
        if (fail_count == 0 && digits_waiting == 0)
            $display("binary_to_decimal_ascii_core_tb: done, clean");
        else
            $display("binary_to_decimal_ascii_core_tb: done, errors");
        $finish;
    end

endmodule

// ===== binary_to_decimal_ascii_core.f =====
rtl/core/b2d_pkg.sv
rtl/core/b2d_num_if.sv
rtl/core/b2d_char_if.sv
rtl/core/b2d_div_stage.sv
rtl/core/b2d_serializer.sv
rtl/core/binary_to_decimal_ascii_core.sv
dv/decimal_char_check.sv
dv/binary_to_decimal_ascii_core_tb.sv
